// ===== design/rsp_pkg.sv =====
package rsp_pkg;

    // field reduction polynomial, low eight bits (x^8 term implied)
    localparam logic [7:0] FIELD_POLY_LO = 8'h1d;
    localparam int         MAX_PARITY_DEF = 32;
    localparam int         RESET_COUNT = 8;
    localparam int         COUNT_W = 6;

    // per-cycle control broadcast along the cell row
    typedef struct packed {
        logic       build;
        logic       absorb;
        logic       load;
        logic       pop;
        logic       clear;
        logic [7:0] mul_b;
    } rsp_ctrl_t;

    // multiply by alpha
    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY_LO : 8'h00);
    endfunction

    // shift-and-add product in the field
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        gf_mul = acc;
    endfunction

endpackage

// ===== design/rsp_ifs.sv =====
interface rsp_msg_if;
    import rsp_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       msg_end;
    modport source (output valid, output data_byte, output msg_end, input ready);
    modport sink (input valid, input data_byte, input msg_end, output ready);
endinterface

interface rsp_par_if;
    import rsp_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] parity_byte;
    logic       parity_last;
    modport source (output valid, output parity_byte, output parity_last, input ready);
    modport sink (input valid, input parity_byte, input parity_last, output ready);
endinterface

interface rsp_cfg_if;
    import rsp_pkg::*;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] parity_count;
    modport source (output valid, output parity_count, input ready);
    modport sink (input valid, input parity_count, output ready);
endinterface

// ===== design/rsp_cell.sv =====
module rsp_cell
    import rsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rsp_ctrl_t  ctrl,
    input  logic [7:0] g_prev,
    output logic [7:0] g_out,
    input  logic [7:0] p_upper,
    output logic [7:0] p_out,
    input  logic [7:0] o_upper,
    output logic [7:0] o_out
);

    logic [7:0] g_reg, g_next;
    logic [7:0] p_reg, p_next;
    logic [7:0] o_reg, o_next;
    logic [7:0] mul_a;
    logic [7:0] prod;
    logic [7:0] p_calc;

    // one shared multiplier: generator build or message absorb
    assign mul_a  = ctrl.build ? g_prev : g_reg;
    assign prod   = gf_mul(mul_a, ctrl.mul_b);
    assign p_calc = p_upper ^ prod;

    // next values
    always_comb
    begin
        g_next = g_reg;
        p_next = p_reg;
        o_next = o_reg;
        priority if (ctrl.clear)
        begin
            g_next = 8'h00;
            p_next = 8'h00;
        end
        else if (ctrl.build)
        begin
            g_next = g_reg ^ prod;
        end
        else if (ctrl.absorb)
        begin
            p_next = ctrl.load ? 8'h00 : p_calc;
        end
        else
        begin
            // idle: hold coefficient and parity stage
            g_next = g_reg;
            p_next = p_reg;
        end
        if (ctrl.load)
        begin
            o_next = p_calc;
        end
        else if (ctrl.pop)
        begin
            o_next = o_upper;
        end
    end

    // cell state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg <= 8'h00;
            p_reg <= 8'h00;
        end
        else
        begin
            g_reg <= g_next;
            p_reg <= p_next;
        end
    end

    // unload shift stage
    always_ff @(posedge clk)
    begin
        o_reg <= o_next;
    end

    assign g_out = g_reg;
    assign p_out = p_reg;
    assign o_out = o_reg;

endmodule

// ===== design/rs_parity_encoder.sv =====
// one message beat per cycle when msg.ready; parity of a message appears the cycle
// after its last beat, then streams out one symbol per cycle when parity.ready, n
// symbols per message; the next message is absorbed while parity drains, its last
// beat waiting for the drain; reset and each parity_count write rebuild the row's
// generator (n is 8 after reset), msg not ready; reset clears the parity register
module rs_parity_encoder
    import rsp_pkg::*;
#(
    parameter int MAX_PARITY = MAX_PARITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    rsp_msg_if.sink   msg,
    rsp_par_if.source parity,
    rsp_cfg_if.sink   cfg
);

    localparam int CW = $clog2(MAX_PARITY + 1);
    localparam int RST_N_ACT = (RESET_COUNT > MAX_PARITY) ? MAX_PARITY : RESET_COUNT;

    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] step_reg, step_next;
    logic [CW-1:0] out_cnt_reg, out_cnt_next;
    logic [7:0]    root_reg, root_next;
    logic [CW-1:0] n_cfg;
    logic [6:0]    cnt7;
    logic          building;
    logic          unload_free;
    logic          msg_beat;
    logic          par_beat;
    logic          cfg_beat;
    logic [7:0]    fb;
    rsp_ctrl_t     ctrl;

    logic [7:0] g_w [MAX_PARITY+1];
    logic [7:0] p_w [MAX_PARITY+1];
    logic [7:0] o_w [MAX_PARITY+1];

    // saturate the written count into 1 .. MAX_PARITY
    assign cnt7 = {1'b0, cfg.parity_count};
    always_comb
    begin
        priority if (cnt7 == 7'd0)
        begin
            n_cfg = CW'(1);
        end
        else if (int'(cnt7) > MAX_PARITY)
        begin
            n_cfg = CW'(MAX_PARITY);
        end
        else
        begin
            n_cfg = CW'(cnt7);
        end
    end

    // handshakes
    assign building    = (step_reg != '0);
    assign unload_free = (out_cnt_reg == '0) || ((out_cnt_reg == CW'(1)) && parity.ready);
    assign msg.ready   = !building && (!msg.msg_end || unload_free);
    assign cfg.ready   = 1'b1;
    assign msg_beat    = msg.valid && msg.ready;
    assign par_beat    = parity.valid && parity.ready;
    assign cfg_beat    = cfg.valid && cfg.ready;

    // feedback symbol and row control
    assign fb = msg.data_byte ^ p_w[0];
    always_comb
    begin
        ctrl.build  = building;
        ctrl.absorb = msg_beat;
        ctrl.load   = msg_beat && msg.msg_end;
        ctrl.pop    = par_beat;
        ctrl.clear  = cfg_beat;
        ctrl.mul_b  = building ? root_reg : fb;
    end

    // sequencer next state
    always_comb
    begin
        n_next       = n_reg;
        step_next    = step_reg;
        root_next    = root_reg;
        out_cnt_next = out_cnt_reg;
        priority if (cfg_beat)
        begin
            n_next       = n_cfg;
            step_next    = n_cfg;
            root_next    = 8'h01;
            out_cnt_next = '0;
        end
        else
        begin
            if (building)
            begin
                step_next = step_reg - CW'(1);
                root_next = gf_xtime(root_reg);
            end
            if (ctrl.load)
            begin
                out_cnt_next = n_reg;
            end
            else if (par_beat)
            begin
                out_cnt_next = out_cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg       <= CW'(RST_N_ACT);
            step_reg    <= CW'(RST_N_ACT);
            root_reg    <= 8'h01;
            out_cnt_reg <= '0;
        end
        else
        begin
            n_reg       <= n_next;
            step_reg    <= step_next;
            root_reg    <= root_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    // row ends
    assign g_w[0]          = 8'h01;
    assign p_w[MAX_PARITY] = 8'h00;
    assign o_w[MAX_PARITY] = 8'h00;

    // cell row: cell j holds parity stage j and generator coefficient j+1
    for (genvar j = 0; j < MAX_PARITY; j++)
    begin : g_cell
        rsp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .g_prev  (g_w[j]),
            .g_out   (g_w[j+1]),
            .p_upper (p_w[j+1]),
            .p_out   (p_w[j]),
            .o_upper (o_w[j+1]),
            .o_out   (o_w[j])
        );
    end

    // result beat
    assign parity.valid       = (out_cnt_reg != '0);
    assign parity.parity_byte = o_w[0];
    assign parity.parity_last = (out_cnt_reg == CW'(1));

    // checks
    a_no_msg_while_building: assert property (@(posedge clk) disable iff (!rst_n)
        building |-> !msg.ready)
        else $error("message beat offered during generator build");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_beat && msg.msg_end) |=> (out_cnt_reg == $past(n_reg)))
        else $error("parity unload count wrong after last beat");

    a_cfg_starts_build: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_beat |=> (building && !parity.valid))
        else $error("configuration write did not start a rebuild");

endmodule
